>>> rtl/spas_pkg.sv
// Shared types and constants for the sparse polynomial add/subtract merge unit
package spas_pkg;

  localparam int COEF_W     = 16;
  localparam int EXP_W      = 16;
  localparam int RCOEF_W    = 17;
  localparam int OPCODE_W   = 2;
  localparam int IN_DATA_W  = COEF_W + EXP_W;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - RCOEF_W - EXP_W;
  localparam int OUT_USER_W = 2;

  localparam logic [OPCODE_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RUN_ADD  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_RUN_SUB  = 2'd3;

  typedef struct packed {
    logic app_a;
    logic app_b;
    logic start;
    logic sub;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic merge_done;
    logic need_slot;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/spas_ctrl.sv
// Controller state machine: accepts transfers and sequences the merge and final flush
module spas_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [spas_pkg::OPCODE_W-1:0] in_tuser,
  input  spas_pkg::sts_t                sts,
  output spas_pkg::cmd_t                cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MERGE = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;
  logic       is_run;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_run    = in_tuser inside {spas_pkg::OP_RUN_ADD, spas_pkg::OP_RUN_SUB};

  always_comb begin
    cmd.app_a = accept && (in_tuser == spas_pkg::OP_APPEND_A);
    cmd.app_b = accept && (in_tuser == spas_pkg::OP_APPEND_B);
    cmd.start = accept && is_run;
    cmd.sub   = (in_tuser == spas_pkg::OP_RUN_SUB);
    cmd.step  = (state_r == ST_MERGE) && !sts.merge_done && (!sts.need_slot || sts.out_free);
    cmd.flush = (state_r == ST_FLUSH) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_run) state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (sts.merge_done) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/spas_dp.sv
// Datapath: term stores, merge head compare, pending term and output register
module spas_dp #(
  parameter int MAX_TERMS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spas_pkg::cmd_t                  cmd,
  input  logic [spas_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [spas_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic [spas_pkg::OUT_USER_W-1:0] out_tuser,
  output spas_pkg::sts_t                  sts
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);

  logic [spas_pkg::COEF_W-1:0] a_coef_r [MAX_TERMS];
  logic [spas_pkg::EXP_W-1:0]  a_exp_r  [MAX_TERMS];
  logic [spas_pkg::COEF_W-1:0] b_coef_r [MAX_TERMS];
  logic [spas_pkg::EXP_W-1:0]  b_exp_r  [MAX_TERMS];

  logic [spas_pkg::COEF_W-1:0] a_hd_coef_r, b_hd_coef_r;
  logic [spas_pkg::EXP_W-1:0]  a_hd_exp_r, b_hd_exp_r;

  logic [CW-1:0] a_cnt_r, a_cnt_nxt;
  logic [CW-1:0] b_cnt_r, b_cnt_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic          drop_r, drop_nxt;
  logic          sub_r, sub_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic          out_vld_r, out_vld_nxt;

  logic signed [spas_pkg::RCOEF_W-1:0] pend_coef_r, pend_coef_nxt;
  logic [spas_pkg::EXP_W-1:0]          pend_exp_r, pend_exp_nxt;
  logic signed [spas_pkg::RCOEF_W-1:0] out_coef_r, out_coef_nxt;
  logic [spas_pkg::EXP_W-1:0]          out_exp_r, out_exp_nxt;
  logic                                out_last_r, out_last_nxt;
  logic                                out_empty_r, out_empty_nxt;
  logic                                out_ovf_r, out_ovf_nxt;

  logic [spas_pkg::COEF_W-1:0] in_coef;
  logic [spas_pkg::EXP_W-1:0]  in_exp;
  logic                        a_ex, b_ex;
  logic [spas_pkg::EXP_W-1:0]  a_e, b_e;
  logic signed [spas_pkg::RCOEF_W-1:0] a_c, b_c, b_s;
  logic signed [spas_pkg::RCOEF_W-1:0] term_coef;
  logic [spas_pkg::EXP_W-1:0]          term_exp;
  logic                                adv_a, adv_b, term_nz;

  assign in_coef = in_tdata[spas_pkg::COEF_W-1:0];
  assign in_exp  = in_tdata[spas_pkg::IN_DATA_W-1:spas_pkg::COEF_W];

  always_ff @(posedge clk) begin
    if (cmd.app_a && (a_cnt_r != FULL)) begin
      a_coef_r[a_cnt_r[AW-1:0]] <= in_coef;
      a_exp_r[a_cnt_r[AW-1:0]]  <= in_exp;
    end
    if (cmd.app_b && (b_cnt_r != FULL)) begin
      b_coef_r[b_cnt_r[AW-1:0]] <= in_coef;
      b_exp_r[b_cnt_r[AW-1:0]]  <= in_exp;
    end
    a_hd_coef_r <= a_coef_r[ia_nxt[AW-1:0]];
    a_hd_exp_r  <= a_exp_r[ia_nxt[AW-1:0]];
    b_hd_coef_r <= b_coef_r[ib_nxt[AW-1:0]];
    b_hd_exp_r  <= b_exp_r[ib_nxt[AW-1:0]];
  end

  assign a_ex = (ia_r == a_cnt_r);
  assign b_ex = (ib_r == b_cnt_r);
  assign a_e  = a_hd_exp_r;
  assign b_e  = b_hd_exp_r;
  assign a_c  = {a_hd_coef_r[spas_pkg::COEF_W-1], a_hd_coef_r};
  assign b_c  = {b_hd_coef_r[spas_pkg::COEF_W-1], b_hd_coef_r};
  assign b_s  = sub_r ? -b_c : b_c;

  always_comb begin
    term_coef = b_s;
    term_exp  = b_e;
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    if (a_ex) begin
      adv_b = 1'b1;
    end else if (b_ex || (a_e > b_e)) begin
      term_coef = a_c;
      term_exp  = a_e;
      adv_a     = 1'b1;
    end else if (a_e < b_e) begin
      adv_b = 1'b1;
    end else begin
      term_coef = a_c + b_s;
      term_exp  = a_e;
      adv_a     = 1'b1;
      adv_b     = 1'b1;
    end
  end

  assign term_nz = (term_coef != '0);

  assign sts.merge_done = a_ex && b_ex;
  assign sts.need_slot  = pend_vld_r && term_nz;
  assign sts.out_free   = !out_vld_r || out_tready;

  always_comb begin
    a_cnt_nxt     = a_cnt_r;
    b_cnt_nxt     = b_cnt_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    drop_nxt      = drop_r;
    sub_nxt       = sub_r;
    pend_vld_nxt  = pend_vld_r;
    pend_coef_nxt = pend_coef_r;
    pend_exp_nxt  = pend_exp_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_coef_nxt  = out_coef_r;
    out_exp_nxt   = out_exp_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;

    if (cmd.app_a) begin
      if (a_cnt_r != FULL) a_cnt_nxt = a_cnt_r + CW'(1);
      else drop_nxt = 1'b1;
    end
    if (cmd.app_b) begin
      if (b_cnt_r != FULL) b_cnt_nxt = b_cnt_r + CW'(1);
      else drop_nxt = 1'b1;
    end

    if (cmd.start) begin
      ia_nxt       = '0;
      ib_nxt       = '0;
      sub_nxt      = cmd.sub;
      pend_vld_nxt = 1'b0;
    end

    if (cmd.step) begin
      ia_nxt = ia_r + CW'(adv_a);
      ib_nxt = ib_r + CW'(adv_b);
      if (term_nz) begin
        pend_vld_nxt  = 1'b1;
        pend_coef_nxt = term_coef;
        pend_exp_nxt  = term_exp;
        if (pend_vld_r) begin
          out_vld_nxt   = 1'b1;
          out_coef_nxt  = pend_coef_r;
          out_exp_nxt   = pend_exp_r;
          out_last_nxt  = 1'b0;
          out_empty_nxt = 1'b0;
          out_ovf_nxt   = drop_r;
        end
      end
    end

    if (cmd.flush) begin
      out_vld_nxt   = 1'b1;
      out_coef_nxt  = pend_vld_r ? pend_coef_r : '0;
      out_exp_nxt   = pend_vld_r ? pend_exp_r : '0;
      out_last_nxt  = 1'b1;
      out_empty_nxt = !pend_vld_r;
      out_ovf_nxt   = drop_r;
      pend_vld_nxt  = 1'b0;
      a_cnt_nxt     = '0;
      b_cnt_nxt     = '0;
      drop_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r    <= '0;
      b_cnt_r    <= '0;
      ia_r       <= '0;
      ib_r       <= '0;
      drop_r     <= 1'b0;
      sub_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      a_cnt_r    <= a_cnt_nxt;
      b_cnt_r    <= b_cnt_nxt;
      ia_r       <= ia_nxt;
      ib_r       <= ib_nxt;
      drop_r     <= drop_nxt;
      sub_r      <= sub_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_coef_r <= pend_coef_nxt;
    pend_exp_r  <= pend_exp_nxt;
    out_coef_r  <= out_coef_nxt;
    out_exp_r   <= out_exp_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{spas_pkg::OUT_PAD_W{1'b0}}, out_exp_r, out_coef_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

endmodule

>>> rtl/sparse_polynomial_add_sub.sv
// Top level of the sparse polynomial add/subtract merge unit
//
//  channel | direction | tdata                                | tuser / tlast
//  in_     | slave     | [15:0] coefficient, [31:16] exponent | tuser[1:0] opcode
//  out_    | master    | [16:0] coefficient, [32:17] exponent | tlast, tuser[0] empty, [1] overflow
//
// Appends are taken back to back while no run is in progress.
// A run makes max(a_count, b_count) to a_count + b_count head comparisons, one per cycle
// while the output does not stall the merge, and holds off input until both stores are
// seen exhausted and the final flush is done.
// A surviving term is held until the next one, so the final one can carry tlast.
// Synchronous active-low reset clears counts, the drop flag and all valids.
// Output stalls hold the merge; the output register frees the input side after a run.
module sparse_polynomial_add_sub #(
  parameter int MAX_TERMS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spas_pkg::IN_DATA_W-1:0]  in_tdata,   // coefficient, exponent
  input  logic [spas_pkg::OPCODE_W-1:0]   in_tuser,   // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spas_pkg::OUT_DATA_W-1:0] out_tdata,  // result_coefficient, result_exponent
  output logic                            out_tlast,
  output logic [spas_pkg::OUT_USER_W-1:0] out_tuser   // empty_res, overflow
);

  spas_pkg::cmd_t cmd;
  spas_pkg::sts_t sts;

  spas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  spas_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .sts        (sts)
  );

endmodule

>>> tb/sv/sparse_polynomial_add_sub_tb.sv
// Self-checking testbench for the sparse polynomial add/subtract merge unit
`timescale 1ns / 1ps

module sparse_polynomial_add_sub_tb;

  localparam int COEF_W     = spas_pkg::COEF_W;
  localparam int EXP_W      = spas_pkg::EXP_W;
  localparam int RCOEF_W    = spas_pkg::RCOEF_W;
  localparam int OPCODE_W   = spas_pkg::OPCODE_W;
  localparam int IN_DATA_W  = spas_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = spas_pkg::OUT_DATA_W;
  localparam int OUT_USER_W = spas_pkg::OUT_USER_W;

  localparam int STORE_DEPTH = 32;
  localparam int TOTAL_ITEMS = 270;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 8;

  typedef struct {
    logic signed [RCOEF_W-1:0] coef;
    logic [EXP_W-1:0]          exp;
    logic                      last;
    logic                      empty;
    logic                      ovf;
  } term_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OPCODE_W-1:0]   in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [OUT_USER_W-1:0] out_tuser;

  term_t                    expected_terms[$];
  logic signed [COEF_W-1:0] a_coef[STORE_DEPTH];
  logic [EXP_W-1:0]         a_exp[STORE_DEPTH];
  logic signed [COEF_W-1:0] b_coef[STORE_DEPTH];
  logic [EXP_W-1:0]         b_exp[STORE_DEPTH];
  int                       a_len = 0;
  int                       b_len = 0;
  bit                       append_lost = 1'b0;
  int                       errors = 0;
  int                       items_sent = 0;
  int                       quiet = 0;
  bit                       no_gaps = 1'b0;
  bit                       hold_req = 1'b0;

  sparse_polynomial_add_sub u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] coefficient, [31:16] exponent
    .in_tuser   (in_tuser),   // [1:0] opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [16:0] result_coefficient, [32:17] result_exponent
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)   // [0] empty_res, [1] overflow
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void merge_stores(bit sub);
    term_t            found[$];
    term_t            t;
    int               ia;
    int               ib;
    int               ac;
    int               bc;
    int               acc;
    logic [EXP_W-1:0] ex;
    ia = 0;
    ib = 0;
    while (ia < a_len || ib < b_len) begin
      if (ia >= a_len || (ib < b_len && a_exp[ia] < b_exp[ib])) begin
        bc = b_coef[ib];
        acc = sub ? -bc : bc;
        ex = b_exp[ib];
        ib++;
      end else if (ib >= b_len || a_exp[ia] > b_exp[ib]) begin
        acc = a_coef[ia];
        ex = a_exp[ia];
        ia++;
      end else begin
        ac = a_coef[ia];
        bc = b_coef[ib];
        acc = sub ? ac - bc : ac + bc;
        ex = a_exp[ia];
        ia++;
        ib++;
      end
      if (acc != 0) begin
        t.coef = acc[RCOEF_W-1:0];
        t.exp = ex;
        t.last = 1'b0;
        t.empty = 1'b0;
        t.ovf = append_lost;
        found.push_back(t);
      end
    end
    if (found.size() == 0) begin
      t = '{'0, '0, 1'b1, 1'b1, append_lost};
      found.push_back(t);
    end else begin
      found[found.size()-1].last = 1'b1;
    end
    foreach (found[k]) expected_terms.push_back(found[k]);
    a_len = 0;
    b_len = 0;
    append_lost = 1'b0;
  endfunction

  function automatic void record_transfer(logic [OPCODE_W-1:0] op, logic [COEF_W-1:0] c,
                                          logic [EXP_W-1:0] e);
    case (op)
      spas_pkg::OP_APPEND_A: begin
        if (a_len < STORE_DEPTH) begin
          a_coef[a_len] = c;
          a_exp[a_len] = e;
          a_len++;
        end else begin
          append_lost = 1'b1;
        end
      end
      spas_pkg::OP_APPEND_B: begin
        if (b_len < STORE_DEPTH) begin
          b_coef[b_len] = c;
          b_exp[b_len] = e;
          b_len++;
        end else begin
          append_lost = 1'b1;
        end
      end
      default: begin
        merge_stores(op == spas_pkg::OP_RUN_SUB);
      end
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(logic [OPCODE_W-1:0] op, logic [COEF_W-1:0] c,
                           logic [EXP_W-1:0] e);
    while (!no_gaps && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {e, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    record_transfer(op, c, e);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_terms.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // one pair of polynomials, loaded interleaved, then a run
  task automatic send_pair(int max_slots, bit wide);
    logic [COEF_W-1:0] qa_c[$];
    logic [COEF_W-1:0] qb_c[$];
    logic [EXP_W-1:0]  qa_e[$];
    logic [EXP_W-1:0]  qb_e[$];
    int                slots;
    int                top;
    int                step_max;
    int                cur;
    int                pick;
    int                k;
    bit                scrambled;
    logic [COEF_W-1:0] c;
    logic [EXP_W-1:0]  ex;
    slots = $urandom_range(max_slots);
    scrambled = ($urandom_range(9) == 0);
    top = wide ? $urandom_range(65535, 1000) : $urandom_range(80, 40);
    step_max = top / (slots + 1);
    if (step_max < 1) step_max = 1;
    cur = top;
    for (k = 0; k < slots && cur >= 0; k++) begin
      ex = scrambled ? EXP_W'($urandom) : EXP_W'(cur);
      cur -= $urandom_range(step_max, 1);
      c = COEF_W'($urandom);
      pick = $urandom_range(3);
      if (pick != 1) begin
        qa_c.push_back(c);
        qa_e.push_back(ex);
      end
      if (pick == 1) begin
        qb_c.push_back(c);
        qb_e.push_back(ex);
      end else if (pick >= 2) begin
        case ($urandom_range(2))
          0: qb_c.push_back(COEF_W'($urandom));
          1: qb_c.push_back(c);
          default: qb_c.push_back(-c);
        endcase
        qb_e.push_back(ex);
      end
    end
    while (qa_c.size() + qb_c.size() > 0) begin
      if (qb_c.size() == 0 || (qa_c.size() > 0 && $urandom_range(1))) begin
        send_item(spas_pkg::OP_APPEND_A, qa_c.pop_front(), qa_e.pop_front());
      end else begin
        send_item(spas_pkg::OP_APPEND_B, qb_c.pop_front(), qb_e.pop_front());
      end
    end
    send_item($urandom_range(1) ? spas_pkg::OP_RUN_SUB : spas_pkg::OP_RUN_ADD,
              COEF_W'($urandom), EXP_W'($urandom));
  endtask

  task automatic test_directed_cases();
    send_item(spas_pkg::OP_RUN_ADD, 16'hFFFF, 16'hFFFF);
    send_item(spas_pkg::OP_APPEND_A, 16'h7FFF, 16'hFFFF);
    send_item(spas_pkg::OP_APPEND_A, 16'h8000, 16'd100);
    send_item(spas_pkg::OP_APPEND_A, 16'd1, 16'd0);
    send_item(spas_pkg::OP_APPEND_B, 16'h7FFF, 16'hFFFF);
    send_item(spas_pkg::OP_APPEND_B, 16'h8000, 16'd100);
    send_item(spas_pkg::OP_APPEND_B, 16'd5, 16'd7);
    send_item(spas_pkg::OP_RUN_ADD, 16'd0, 16'd0);
    send_item(spas_pkg::OP_APPEND_A, 16'h8000, 16'd9);
    send_item(spas_pkg::OP_APPEND_B, 16'h7FFF, 16'd9);
    send_item(spas_pkg::OP_RUN_SUB, 16'h5555, 16'hAAAA);
    send_item(spas_pkg::OP_APPEND_A, 16'd5, 16'd3);
    send_item(spas_pkg::OP_APPEND_B, 16'd5, 16'd3);
    send_item(spas_pkg::OP_RUN_SUB, 16'd0, 16'd0);
    send_item(spas_pkg::OP_APPEND_A, 16'd1, 16'd2);
    send_item(spas_pkg::OP_APPEND_A, 16'd1, 16'd50);
    send_item(spas_pkg::OP_APPEND_B, 16'd1, 16'd10);
    send_item(spas_pkg::OP_RUN_ADD, 16'd0, 16'd0);
    send_item(spas_pkg::OP_APPEND_B, 16'h8000, 16'd0);
    send_item(spas_pkg::OP_RUN_SUB, 16'd0, 16'd0);
    wait_for_results();
  endtask

  task automatic test_full_stores();
    int k;
    for (k = 0; k < STORE_DEPTH + 1; k++) begin
      send_item(spas_pkg::OP_APPEND_A, COEF_W'($urandom),
                EXP_W'(2 * (STORE_DEPTH - k) + 1));
    end
    for (k = 0; k < STORE_DEPTH + 2; k++) begin
      send_item(spas_pkg::OP_APPEND_B, COEF_W'($urandom),
                EXP_W'(2 * (STORE_DEPTH - k)));
    end
    send_item(spas_pkg::OP_RUN_SUB, COEF_W'($urandom), EXP_W'($urandom));
    send_item(spas_pkg::OP_RUN_ADD, COEF_W'($urandom), EXP_W'($urandom));
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (4) send_pair(4, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_merges();
    int goal;
    int pairs;
    goal = TOTAL_ITEMS;
    pairs = 0;
    while (items_sent < goal) begin
      no_gaps = (pairs >= 8 && pairs < 16);
      send_pair(($urandom_range(19) == 0) ? 34 : 6, 1'($urandom_range(1)));
      pairs++;
    end
    no_gaps = 1'b0;
    wait_for_results();
  endtask

  initial begin : output_side
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= no_gaps || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin : check_results
    term_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_terms.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[31:0], 32'd0);
      end else begin
        want = expected_terms.pop_front();
        if (out_tdata[RCOEF_W-1:0] !== want.coef)
          report_mismatch("result_coefficient", 32'(out_tdata[RCOEF_W-1:0]),
                          32'(want.coef));
        if (out_tdata[RCOEF_W+EXP_W-1:RCOEF_W] !== want.exp)
          report_mismatch("result_exponent", 32'(out_tdata[RCOEF_W+EXP_W-1:RCOEF_W]),
                          32'(want.exp));
        if (out_tlast !== want.last)
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
        if (out_tuser[0] !== want.empty)
          report_mismatch("empty_res", 32'(out_tuser[0]), 32'(want.empty));
        if (out_tuser[1] !== want.ovf)
          report_mismatch("overflow", 32'(out_tuser[1]), 32'(want.ovf));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = spas_pkg::OP_APPEND_A;
    out_tready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_full_stores();
    test_output_backpressure();
    test_random_merges();
    if (expected_terms.size() != 0)
      report_mismatch("terms never delivered", expected_terms.size(), 32'd0);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
